// ----- design/binary_majority_filter_5x5_macros.svh -----
// Assertion helpers for the majority filter checker.
`ifndef BINARY_MAJORITY_FILTER_5X5_MACROS_SVH
`define BINARY_MAJORITY_FILTER_5X5_MACROS_SVH

// same-cycle implication
`define BMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bmf_pkg.sv -----
package bmf_pkg;

  localparam int WIN             = 5;
  localparam int LINES           = 4;
  localparam int INTERIOR_FACTOR = 13;
  localparam int LIMIT_THREE     = 5 * 3 / 2 + 1;
  localparam int LIMIT_FOUR      = 5 * 4 / 2 + 1;

  localparam logic [10:0] FW_RESET = 11'd640;
  localparam logic [11:0] FH_RESET = 12'd480;
  localparam logic [7:0]  FG_RESET = 8'd255;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FG_VALUE     = 2'd2
  } cfg_reg_t;

  typedef logic [7:0] pixel_t;

  // per-pixel info carried from the counters into the window stage
  typedef struct packed {
    pixel_t      px;
    logic [1:0]  y2;
    logic        has_res;
    logic        last_row;
    logic        last_col;
    logic [2:0]  ylo;
    logic [1:0]  xlo;
  } item_t;

  // weighted row partials for one result
  typedef struct packed {
    logic [WIN-1:0][12:0] row_sum;
    logic [WIN-1:0][4:0]  row_cnt;
    logic [1:0]           jlo;
    logic                 run_last;
    logic                 frame_done;
  } part_t;

endpackage

// ----- design/bmf_line_store.sv -----
module bmf_line_store
  import bmf_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [8*LINES-1:0]   rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [8*LINES-1:0]   wr_data
);

  // one word per column, one byte lane per buffered row
  logic [8*LINES-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/bmf_window.sv -----
module bmf_window
  import bmf_pkg::*;
#(
  parameter int XW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_load,
  input  logic [XW-1:0]       in_x,
  input  item_t               in_item,
  output logic                s1_free,
  input  logic [8*LINES-1:0]  rd_data,
  output logic                wr_en,
  output logic [XW-1:0]       wr_addr,
  output logic [8*LINES-1:0]  wr_data,
  output logic                part_valid,
  input  logic                part_ready,
  output part_t               part
);

  logic          s1_valid;
  logic [XW-1:0] s1_x;
  item_t         s1_item;
  logic          s1_go;

  logic       s2_valid;
  logic [1:0] ri;
  logic [1:0] ci;
  logic [1:0] nr_m;
  logic [1:0] nc_m;
  logic [2:0] s2_ylo;
  logic [1:0] s2_xlo;
  logic       s2_fend;
  logic       s2_last;
  logic       s2_emit;
  logic       s2_done;
  logic       s2_free;

  pixel_t     win [WIN][WIN];
  pixel_t     col [WIN];
  logic [1:0] jlo;
  logic [10:0] rsum [WIN];
  logic [2:0]  rcnt [WIN];
  logic [2:0]  slot [WIN];
  logic [2:0]  mult [WIN];

  assign s2_last = (ri == nr_m) && (ci == nc_m);
  assign s2_emit = s2_valid && part_ready;
  assign s2_done = s2_emit && s2_last;
  assign s2_free = !s2_valid || s2_done;
  assign s1_go   = s1_valid && s2_free;
  assign s1_free = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_load) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_x    <= in_x;
      s1_item <= in_item;
    end
  end

  // new window column: rows y-4..y-1 from the line store lanes, row y is the pixel
  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      col[k] = rd_data[8*(2'(s1_item.y2 + 2'(k))) +: 8];
    end
    col[WIN-1] = s1_item.px;
    wr_data = rd_data;
    wr_data[8*s1_item.y2 +: 8] = s1_item.px;
  end

  assign wr_en   = s1_go;
  assign wr_addr = s1_x;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int k = 0; k < WIN; k++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win[k][j] <= win[k][j+1];
        end
        win[k][WIN-1] <= col[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go) begin
      s2_valid <= s1_item.has_res;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      ri      <= 2'd0;
      ci      <= 2'd0;
      nr_m    <= s1_item.last_row ? 2'd2 : 2'd0;
      nc_m    <= s1_item.last_col ? 2'd2 : 2'd0;
      s2_ylo  <= s1_item.ylo;
      s2_xlo  <= s1_item.xlo;
      s2_fend <= s1_item.last_row && s1_item.last_col;
    end else if (s2_emit && !s2_last) begin
      if (ci == nc_m) begin
        ci <= 2'd0;
        ri <= ri + 2'd1;
      end else begin
        ci <= ci + 2'd1;
      end
    end
  end

  // rows repeated at the frame edges show up as a multiplicity per window row;
  // rows above the frame top hold unwritten lanes and are left out entirely
  always_comb begin
    jlo = (ci > s2_xlo) ? ci : s2_xlo;
    for (int k = 0; k < WIN; k++) begin
      rsum[k] = '0;
      rcnt[k] = '0;
      for (int j = 0; j < WIN; j++) begin
        if ((3'(j) >= {1'b0, jlo}) && (3'(k) >= s2_ylo)) begin
          rsum[k] = rsum[k] + 11'(win[k][j]);
          rcnt[k] = rcnt[k] + 3'(win[k][j] != 8'd0);
        end
      end
    end
    for (int d = 0; d < WIN; d++) begin
      slot[d] = 3'({1'b0, ri}) + 3'(d);
      if (slot[d] > 3'd4) slot[d] = 3'd4;
      if (slot[d] < s2_ylo) slot[d] = s2_ylo;
    end
    for (int k = 0; k < WIN; k++) begin
      mult[k] = '0;
      for (int d = 0; d < WIN; d++) begin
        if (slot[d] == 3'(k)) mult[k] = mult[k] + 3'd1;
      end
    end
    for (int k = 0; k < WIN; k++) begin
      part.row_sum[k] = 13'({3'b0, rsum[k]} * {11'b0, mult[k]});
      part.row_cnt[k] = 5'({3'b0, rcnt[k]} * {3'b0, mult[k]});
    end
    part.jlo        = jlo;
    part.run_last   = s2_last;
    part.frame_done = s2_last && s2_fend;
  end

  assign part_valid = s2_valid;

endmodule

// ----- design/bmf_judge.sv -----
module bmf_judge
  import bmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        part_valid,
  output logic        part_ready,
  input  part_t       part,
  input  pixel_t      fg,
  input  logic [11:0] fg13,
  output logic        out_valid,
  input  logic        out_stall,
  output pixel_t      pixel_out,
  output logic        run_last,
  output logic        frame_done
);

  logic        s3_valid;
  part_t       s3_part;
  logic        s3_free;
  logic        out_free;
  logic [12:0] total;
  logic [4:0]  cnt;
  logic        hit;

  assign out_free   = !out_valid || !out_stall;
  assign s3_free    = !s3_valid || out_free;
  assign part_ready = s3_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= part_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && part_valid) begin
      s3_part <= part;
    end
  end

  always_comb begin
    total = '0;
    cnt   = '0;
    for (int k = 0; k < WIN; k++) begin
      total = total + s3_part.row_sum[k];
      cnt   = cnt + s3_part.row_cnt[k];
    end
    case (s3_part.jlo)
      2'd0:    hit = total > {1'b0, fg13};
      2'd1:    hit = cnt > 5'(LIMIT_FOUR);
      2'd2:    hit = cnt > 5'(LIMIT_THREE);
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s3_valid) begin
      pixel_out  <= hit ? fg : 8'd0;
      run_last   <= s3_part.run_last;
      frame_done <= s3_part.frame_done;
    end
  end

endmodule

// ----- design/binary_majority_filter_5x5.sv -----
// 5x5 majority filter for binary-like 8-bit images, one pixel per transfer.
// Input: pixels in raster order on in_valid/in_stall/pixel_in. Output: filtered
// pixels (0 or fg_value) on out_valid/out_stall with run_last marking the last
// result of an input pixel and frame_done the frame's final result.
// Config: cfg_valid/cfg_ready write frame_width (0), frame_height (1) and
// fg_value (2); cfg_ready is always high. Geometry writes restart the frame.
// Throughput: one pixel per clock while each pixel yields one result and the
// output is not stalled. A pixel on the last column yields 3 results, on the last
// row 3, at the frame's last pixel 9; the result sequencer emits one per clock
// unless stalled, and holds input meanwhile. A result passes the line store read, the
// window shift with row partials, the partial register and the decision register.
// Rows 0-1 and columns 0-1 of each row yield nothing; their results come later.
// The row store is a single-port-per-side RAM of MAX_WIDTH words, four rows wide.
// Reset clears counters and pipeline valids and loads default geometry and
// fg_value; the RAM needs no clearing. A stalled output holds its result; once every
// stage is full the stall reaches in_stall in the same cycle.
module binary_majority_filter_5x5
  import bmf_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_out,
  output logic        run_last,
  output logic        frame_done
);

  localparam int XW = $clog2(MAX_WIDTH);

  logic [10:0]        frame_width;
  logic [11:0]        frame_height;
  pixel_t             fg_value;
  logic [11:0]        fg13;
  logic [XW-1:0]      x;
  logic [11:0]        y;
  logic [XW-1:0]      w_m1;
  logic [11:0]        h_m1;
  logic               accept;
  logic               s1_free;
  logic               cfg_wr;
  item_t              item;
  logic [8*LINES-1:0] rd_data;
  logic               wr_en;
  logic [XW-1:0]      wr_addr;
  logic [8*LINES-1:0] wr_data;
  logic               part_valid;
  logic               part_ready;
  part_t              part;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = !s1_free;
  assign accept    = in_valid && s1_free;

  always_comb begin
    if (frame_width < 11'd5) begin
      w_m1 = XW'(4);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_m1 = XW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = XW'(frame_width - 11'd1);
    end
    h_m1 = (frame_height < 12'd5) ? 12'd4 : frame_height - 12'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
      fg_value     <= FG_RESET;
      fg13         <= 12'(FG_RESET * INTERIOR_FACTOR);
      x            <= '0;
      y            <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[10:0];
          x <= '0;
          y <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
          x <= '0;
          y <= '0;
        end
        REG_FG_VALUE: begin
          fg_value <= cfg_data[7:0];
          fg13     <= 12'({4'b0, cfg_data[7:0]} * 12'(INTERIOR_FACTOR));
        end
        default: ;
      endcase
    end else if (accept) begin
      if (x == w_m1) begin
        x <= '0;
        y <= (y == h_m1) ? 12'd0 : y + 12'd1;
      end else begin
        x <= x + XW'(1);
      end
    end
  end

  always_comb begin
    item.px       = pixel_in;
    item.y2       = y[1:0];
    item.has_res  = (y >= 12'd2) && (32'(x) >= 32'd2);
    item.last_row = (y == h_m1);
    item.last_col = (x == w_m1);
    item.ylo      = (y < 12'd4) ? 3'd4 - {1'b0, y[1:0]} : 3'd0;
    item.xlo      = (32'(x) < 32'd4) ? 2'(32'd4 - 32'(x)) : 2'd0;
  end

  bmf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (x),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bmf_window #(
    .XW (XW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .in_load    (accept),
    .in_x       (x),
    .in_item    (item),
    .s1_free    (s1_free),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .part_valid (part_valid),
    .part_ready (part_ready),
    .part       (part)
  );

  bmf_judge u_judge (
    .clk        (clk),
    .rst        (rst),
    .part_valid (part_valid),
    .part_ready (part_ready),
    .part       (part),
    .fg         (fg_value),
    .fg13       (fg13),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .run_last   (run_last),
    .frame_done (frame_done)
  );

endmodule

// ----- design/bmf_checker.sv -----
`include "binary_majority_filter_5x5_macros.svh"

module bmf_checker
  import bmf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [11:0] cfg_data,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  pixel_out,
  input logic        run_last,
  input logic        frame_done
);

  pixel_t fg_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_seen <= FG_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_FG_VALUE) begin
      fg_seen <= cfg_data[7:0];
    end
  end

  `BMF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `BMF_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(pixel_out), "stalled result changed")
  `BMF_ASSERT_IMP(a_binary, out_valid, pixel_out == 8'd0 || pixel_out == fg_seen, "non-binary result")
  `BMF_ASSERT_IMP(a_done_last, out_valid && frame_done, run_last, "frame end not last of run")

endmodule

bind binary_majority_filter_5x5 bmf_checker u_checker (.*);
